// ----- rtl/core/shp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// shared constants, codes and types of the spatial hash point table
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int CAPACITY     = 1024;
  localparam int BUCKET_COUNT = 128;
  localparam int MAX_MATCHES  = 64;
  localparam int NUM_PROBES   = 9;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = IDX_W + 1;
  localparam int BKT_W  = $clog2(BUCKET_COUNT);
  localparam int NF_W   = $clog2(MAX_MATCHES + 1);
  localparam int CELL_W = 49;
  localparam int PRB_W  = $clog2(NUM_PROBES + 1);

  localparam logic [CNT_W-1:0] EMPTY_LINK = '1;

  // operations
  localparam logic [1:0] OP_ADD        = 2'd0;
  localparam logic [1:0] OP_ADD_UNIQUE = 2'd1;
  localparam logic [1:0] OP_FIND_FIRST = 2'd2;
  localparam logic [1:0] OP_FIND_ALL   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_MATCHED = 3'd1;
  localparam logic [2:0] ST_NOMATCH = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y  = 3'd1;
  localparam logic [2:0] REG_BOX_MAX_X  = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_Y  = 3'd3;
  localparam logic [2:0] REG_INV_CELL   = 3'd4;
  localparam logic [2:0] REG_PROBE_OFF  = 3'd5;
  localparam logic [2:0] REG_RADIUS_SQ  = 3'd6;
  localparam logic [2:0] REG_ROW_STRIDE = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] link;
    logic [31:0]      x;
    logic [31:0]      y;
  } pt_t;

  typedef struct packed {
    logic             we;
    logic [BKT_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [BKT_W-1:0] raddr;
  } head_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    pt_t              wdata;
    logic [IDX_W-1:0] raddr;
  } pt_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CX,
    S_CY,
    S_CELL,
    S_HEAD,
    S_HWAIT,
    S_CHECK,
    S_PWAIT,
    S_SQX,
    S_SQY,
    S_PUSH,
    S_END,
    S_AWRITE,
    S_FINAL
  } state_e;

endpackage

// ----- rtl/core/shp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_if
// input and output word channels of the spatial hash point table
// ----------------------------------------------------------------------------
interface shp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] x_coord;
  logic [31:0] y_coord;

  modport source (output valid, op, x_coord, y_coord, input ready);
  modport sink   (input valid, op, x_coord, y_coord, output ready);
endinterface

interface shp_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] point_index;
  logic [2:0] status;
  logic       last;

  modport source (output valid, point_index, status, last, input ready);
  modport sink   (input valid, point_index, status, last, output ready);
endinterface

// ----- rtl/core/shp_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_mul
// shared 32x32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module shp_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/core/shp_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_store
// bucket head memory with valid bits and point memory (link, x, y)
// ----------------------------------------------------------------------------
module shp_store (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  shp_pkg::head_req_t      head_req_i,
  output logic [shp_pkg::CNT_W-1:0] head_rdata_o,
  input  shp_pkg::pt_req_t        pt_req_i,
  output shp_pkg::pt_t            pt_rdata_o
);
  import shp_pkg::*;

  logic [CNT_W-1:0]        head_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] head_vld_q;
  logic [CNT_W-1:0]        head_rd_q;
  logic                    head_rv_q;
  pt_t                     pt_mem [CAPACITY];
  pt_t                     pt_rd_q;

  always_ff @(posedge clk_i) begin
    if (head_req_i.we) begin
      head_mem[head_req_i.waddr] <= head_req_i.wdata;
    end
    head_rd_q <= head_mem[head_req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      head_rv_q  <= 1'b0;
    end else begin
      if (head_req_i.we) begin
        head_vld_q[head_req_i.waddr] <= 1'b1;
      end
      head_rv_q <= head_vld_q[head_req_i.raddr];
    end
  end

  // untouched bucket reads as an empty chain
  assign head_rdata_o = head_rv_q ? head_rd_q : EMPTY_LINK;

  always_ff @(posedge clk_i) begin
    if (pt_req_i.we) begin
      pt_mem[pt_req_i.waddr] <= pt_req_i.wdata;
    end
    pt_rd_q <= pt_mem[pt_req_i.raddr];
  end

  assign pt_rdata_o = pt_rd_q;

endmodule

// ----- rtl/core/spatial_hash_close_point_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_close_point_table
// grid hash of Q16.16 points with radius search, add and add-unique
// ----------------------------------------------------------------------------
// flow: an add computes its cell and writes the point, then leaves its result
//   in the output register; a search tests each probe, computes the cell of
//   those inside the box, then walks each visited bucket chain entry by entry
// throughput: one word at a time; the next word is taken once the last
//   result of the current word sits in the output register
// reset: clears bucket valid bits and the point count at once, no sweep
// ----------------------------------------------------------------------------
module spatial_hash_close_point_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  shp_in_if.sink      in_i,
  shp_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [62:0] cfg_data_i
);
  import shp_pkg::*;

  // configuration registers
  logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic [31:0]        inv_cell_q;
  logic [30:0]        probe_off_q;
  logic [62:0]        radius_sq_q;
  logic [15:0]        stride_q;

  // control
  state_e state_q, state_d;

  // word under work
  logic [1:0]         op_q;
  logic signed [31:0] x_q, y_q;
  logic               add_q;
  logic [1:0]         ia_q, ib_q;
  logic [31:0]        dy_q, cx_q;
  logic [CELL_W-1:0]  cells_q [NUM_PROBES];
  logic [PRB_W-1:0]   ncells_q, c_q;
  logic [CNT_W-1:0]   i_q, link_q;
  logic [31:0]        ay_q;
  logic [63:0]        sx_q;
  logic [NF_W-1:0]    nfound_q, limit;
  logic               has_pend_q;
  logic [IDX_W-1:0]   res_idx_q, new_idx_q;
  logic [2:0]         res_st_q;
  logic [BKT_W-1:0]   bucket_q;
  logic [CNT_W-1:0]   count_q;

  // output register
  logic             out_vld_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [2:0]       out_st_q;
  logic             out_last_q;
  logic             out_free;
  logic             push;
  logic             push_last;

  // shared units
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  head_req_t        head_req;
  logic [CNT_W-1:0] head_rdata;
  pt_req_t          pt_req;
  pt_t              pt_rdata;

  shp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  shp_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_req_i   (head_req),
    .head_rdata_o (head_rdata),
    .pt_req_i     (pt_req),
    .pt_rdata_o   (pt_rdata)
  );

  // ---------------- probe point and box test ----------------
  logic signed [33:0] off_e, xe, ye, px, py, pdx, pdy;
  logic               in_box, last_probe;

  always_comb begin
    off_e = {3'b000, probe_off_q};
    xe    = 34'(x_q);
    ye    = 34'(y_q);
    case (ia_q)
      2'd0:    px = xe - off_e;
      2'd2:    px = xe + off_e;
      default: px = xe;
    endcase
    case (ib_q)
      2'd0:    py = ye - off_e;
      2'd2:    py = ye + off_e;
      default: py = ye;
    endcase
    in_box = (px >= 34'(min_x_q)) && (px < 34'(max_x_q)) &&
             (py >= 34'(min_y_q)) && (py < 34'(max_y_q));
    // offsets from the box minimum, below 2^32 when inside
    pdx = px - 34'(min_x_q);
    pdy = py - 34'(min_y_q);
  end

  assign last_probe = (ia_q == 2'd2) && (ib_q == 2'd2);

  // ---------------- cell number and duplicate check ----------------
  logic [CELL_W-1:0] cell_num;
  logic              dup;

  assign cell_num = {1'b0, prod[CELL_W-2:0]} + {17'd0, cx_q};

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < NUM_PROBES; k++) begin
      if ((PRB_W'(k) < ncells_q) && (cells_q[k] == cell_num)) begin
        dup = 1'b1;
      end
    end
  end

  // ---------------- distance test ----------------
  logic signed [32:0] dxs, dys;
  logic [31:0]        ax, ay;
  logic [64:0]        dsum;
  logic               close;

  always_comb begin
    dxs   = 33'(x_q) - 33'($signed(pt_rdata.x));
    dys   = 33'(y_q) - 33'($signed(pt_rdata.y));
    ax    = dxs[32] ? 32'(-dxs) : dxs[31:0];
    ay    = dys[32] ? 32'(-dys) : dys[31:0];
    dsum  = {1'b0, sx_q} + {1'b0, prod};
    // a carry out means the sum saturated and never matches
    close = !dsum[64] && (dsum[63:0] < {1'b0, radius_sq_q});
  end

  assign limit    = (op_q == OP_FIND_ALL) ? NF_W'(MAX_MATCHES) : NF_W'(1);
  assign out_free = !out_vld_q || out_o.ready;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_PROBE;
      S_PROBE: begin
        if (in_box) begin
          state_d = S_CX;
        end else if (add_q) begin
          state_d = S_FINAL;
        end else if (last_probe) begin
          state_d = S_HEAD;
        end
      end
      S_CX:    state_d = S_CY;
      S_CY:    state_d = S_CELL;
      S_CELL: begin
        if (add_q) begin
          state_d = (count_q >= CNT_W'(CAPACITY)) ? S_FINAL : S_AWRITE;
        end else begin
          state_d = last_probe ? S_HEAD : S_PROBE;
        end
      end
      S_HEAD:  state_d = (c_q == ncells_q) ? S_END : S_HWAIT;
      S_HWAIT: state_d = S_CHECK;
      S_CHECK: state_d = (i_q >= count_q) ? S_HEAD : S_PWAIT;
      S_PWAIT: state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY: begin
        if (close) begin
          if (has_pend_q) begin
            state_d = S_PUSH;
          end else if (nfound_q + NF_W'(1) == limit) begin
            state_d = S_FINAL;
          end else begin
            state_d = S_CHECK;
          end
        end else begin
          state_d = S_CHECK;
        end
      end
      S_PUSH: begin
        if (out_free) state_d = (nfound_q == limit) ? S_FINAL : S_CHECK;
      end
      S_END: begin
        if (has_pend_q || (op_q == OP_FIND_FIRST) || (op_q == OP_FIND_ALL)) begin
          state_d = S_FINAL;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_AWRITE: state_d = S_FINAL;
      S_FINAL:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------- unit controls ----------------
  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    head_req       = '0;
    pt_req         = '0;
    push           = 1'b0;
    push_last      = 1'b0;
    head_req.raddr = cells_q[c_q][BKT_W-1:0];
    pt_req.raddr   = i_q[IDX_W-1:0];
    case (state_q)
      S_PROBE: begin
        mul_a = pdx[31:0];
        mul_b = inv_cell_q;
      end
      S_CX: begin
        mul_a = dy_q;
        mul_b = inv_cell_q;
      end
      S_CY: begin
        mul_a = prod[63:32];
        mul_b = {16'd0, stride_q};
      end
      S_CELL:  head_req.raddr = cell_num[BKT_W-1:0];
      S_PWAIT: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQX: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      S_PUSH:  push = out_free;
      S_AWRITE: begin
        // new point goes to the front of its bucket chain
        head_req.we    = 1'b1;
        head_req.waddr = bucket_q;
        head_req.wdata = count_q;
        pt_req.we      = 1'b1;
        pt_req.waddr   = count_q[IDX_W-1:0];
        pt_req.wdata   = '{link: head_rdata, x: x_q, y: y_q};
      end
      S_FINAL: begin
        push      = out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_AWRITE) count_q <= count_q + CNT_W'(1);
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q     <= '0;
      min_y_q     <= '0;
      max_x_q     <= 32'sd65536;
      max_y_q     <= 32'sd65536;
      inv_cell_q  <= 32'd65536;
      probe_off_q <= '0;
      radius_sq_q <= '0;
      stride_q    <= 16'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_MIN_X:  min_x_q     <= cfg_data_i[31:0];
        REG_BOX_MIN_Y:  min_y_q     <= cfg_data_i[31:0];
        REG_BOX_MAX_X:  max_x_q     <= cfg_data_i[31:0];
        REG_BOX_MAX_Y:  max_y_q     <= cfg_data_i[31:0];
        REG_INV_CELL:   inv_cell_q  <= cfg_data_i[31:0];
        REG_PROBE_OFF:  probe_off_q <= cfg_data_i[30:0];
        REG_RADIUS_SQ:  radius_sq_q <= cfg_data_i;
        REG_ROW_STRIDE: stride_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_idx_q  <= res_idx_q;
      out_st_q   <= push_last ? res_st_q : ST_MATCHED;
      out_last_q <= push_last;
    end
    case (state_q)
      S_IDLE: begin
        op_q       <= in_i.op;
        x_q        <= in_i.x_coord;
        y_q        <= in_i.y_coord;
        add_q      <= (in_i.op == OP_ADD);
        ia_q       <= (in_i.op == OP_ADD) ? 2'd1 : 2'd0;
        ib_q       <= (in_i.op == OP_ADD) ? 2'd1 : 2'd0;
        ncells_q   <= '0;
        c_q        <= '0;
        nfound_q   <= '0;
        has_pend_q <= 1'b0;
      end
      S_PROBE: begin
        dy_q <= pdy[31:0];
        if (!in_box) begin
          if (add_q) begin
            res_idx_q <= '0;
            res_st_q  <= ST_OUTSIDE;
          end else if (ib_q == 2'd2) begin
            ib_q <= 2'd0;
            ia_q <= ia_q + 2'd1;
          end else begin
            ib_q <= ib_q + 2'd1;
          end
        end
      end
      S_CX: cx_q <= prod[63:32];
      S_CELL: begin
        bucket_q <= cell_num[BKT_W-1:0];
        if (add_q) begin
          res_idx_q <= '0;
          res_st_q  <= ST_FULL;
        end else begin
          if (!dup) begin
            cells_q[ncells_q] <= cell_num;
            ncells_q          <= ncells_q + PRB_W'(1);
          end
          if (ib_q == 2'd2) begin
            ib_q <= 2'd0;
            ia_q <= ia_q + 2'd1;
          end else begin
            ib_q <= ib_q + 2'd1;
          end
        end
      end
      S_HWAIT: i_q <= head_rdata;
      S_CHECK: if (i_q >= count_q) c_q <= c_q + PRB_W'(1);
      S_PWAIT: begin
        link_q <= pt_rdata.link;
        ay_q   <= ay;
      end
      S_SQX: sx_q <= prod;
      S_SQY: begin
        i_q <= link_q;
        if (close) begin
          nfound_q <= nfound_q + NF_W'(1);
          if (has_pend_q) begin
            new_idx_q <= i_q[IDX_W-1:0];
          end else begin
            res_idx_q  <= i_q[IDX_W-1:0];
            res_st_q   <= ST_MATCHED;
            has_pend_q <= 1'b1;
          end
        end
      end
      S_PUSH: if (out_free) res_idx_q <= new_idx_q;
      S_END: begin
        if (!has_pend_q) begin
          res_idx_q <= '0;
          res_st_q  <= ST_NOMATCH;
          // add-unique with no match falls through to the add
          add_q     <= 1'b1;
          ia_q      <= 2'd1;
          ib_q      <= 2'd1;
        end
      end
      S_AWRITE: begin
        res_idx_q <= count_q[IDX_W-1:0];
        res_st_q  <= ST_ADDED;
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.point_index = out_idx_q;
  assign out_o.status      = out_st_q;
  assign out_o.last        = out_last_q;

endmodule

// ----- bench/shp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_checker
// Watches the word channels and the register port of the spatial hash point
// table, keeps its own copy of the grid hash and compares every result word.
// ----------------------------------------------------------------------------
module shp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  in_op_i,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [9:0]  out_index_i,
  input  logic [2:0]  out_status_i,
  input  logic        out_last_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [62:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);
  import shp_pkg::*;

  typedef struct packed {
    logic [9:0] index;
    logic [2:0] status;
    logic       last;
  } result_t;

  result_t     result_q[$];
  int          mismatches;

  longint      min_x, min_y, max_x, max_y;
  bit [63:0]   inv_cell, probe_off, radius_sq, stride;

  int          heads[BUCKET_COUNT];
  int          links[CAPACITY];
  longint      pt_x[CAPACITY];
  longint      pt_y[CAPACITY];
  int          count;

  function automatic bit cell_of(longint x, longint y, output bit [63:0] cell_no);
    bit [63:0] cx, cy;
    if (x < min_x || x >= max_x || y < min_y || y >= max_y) return 0;
    cx = (64'(x - min_x) * inv_cell) >> 32;
    cy = (64'(y - min_y) * inv_cell) >> 32;
    cell_no = cx + cy * stride;
    return 1;
  endfunction

  function automatic bit is_close(longint x, longint y, int i);
    longint    dx, dy;
    bit [63:0] ax, ay;
    bit [64:0] sum;
    dx = x - pt_x[i];
    dy = y - pt_y[i];
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sum = {1'b0, ax * ax} + {1'b0, ay * ay};
    // squared distance of 2^64 or more saturates
    if (sum[64]) return 0;
    return sum[63:0] < radius_sq;
  endfunction

  // points within the radius in probe-cell order, chain order within a cell
  function automatic void collect_matches(longint x, longint y, int limit,
                                          ref int found[$]);
    bit [63:0] cells[$];
    bit [63:0] cl;
    bit        dup;
    int        i, steps;
    for (int a = -1; a <= 1; a++) begin
      for (int b = -1; b <= 1; b++) begin
        if (cell_of(x + a * longint'(probe_off), y + b * longint'(probe_off), cl)) begin
          dup = 0;
          foreach (cells[c]) if (cells[c] == cl) dup = 1;
          if (!dup) cells.push_back(cl);
        end
      end
    end
    foreach (cells[c]) begin
      i = heads[cells[c] % BUCKET_COUNT];
      steps = 0;
      while (i >= 0 && i < count && steps < CAPACITY) begin
        if (is_close(x, y, i)) begin
          found.push_back(i);
          if (found.size() >= limit) return;
        end
        i = links[i];
        steps++;
      end
    end
  endfunction

  function automatic void predict_word(logic [1:0] op, logic [31:0] xi, logic [31:0] yi);
    int        found[$];
    longint    x, y;
    bit [63:0] cl;
    x = longint'($signed(xi));
    y = longint'($signed(yi));
    if (op != OP_ADD) begin
      collect_matches(x, y, (op == OP_FIND_ALL) ? MAX_MATCHES : 1, found);
      if (found.size() > 0) begin
        if (op != OP_FIND_ALL) found = found[0:0];
        foreach (found[k])
          result_q.push_back('{found[k][9:0], ST_MATCHED, k == found.size() - 1});
        return;
      end
      if (op != OP_ADD_UNIQUE) begin
        result_q.push_back('{10'd0, ST_NOMATCH, 1'b1});
        return;
      end
    end
    if (!cell_of(x, y, cl)) begin
      result_q.push_back('{10'd0, ST_OUTSIDE, 1'b1});
    end else if (count >= CAPACITY) begin
      result_q.push_back('{10'd0, ST_FULL, 1'b1});
    end else begin
      pt_x[count] = x;
      pt_y[count] = y;
      links[count] = heads[cl % BUCKET_COUNT];
      heads[cl % BUCKET_COUNT] = count;
      result_q.push_back('{count[9:0], ST_ADDED, 1'b1});
      count++;
    end
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [62:0] d);
    case (idx)
      REG_BOX_MIN_X:  min_x = longint'($signed(d[31:0]));
      REG_BOX_MIN_Y:  min_y = longint'($signed(d[31:0]));
      REG_BOX_MAX_X:  max_x = longint'($signed(d[31:0]));
      REG_BOX_MAX_Y:  max_y = longint'($signed(d[31:0]));
      REG_INV_CELL:   inv_cell = 64'(d[31:0]);
      REG_PROBE_OFF:  probe_off = 64'(d[30:0]);
      REG_RADIUS_SQ:  radius_sq = 64'(d);
      REG_ROW_STRIDE: stride = 64'(d[15:0]);
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      min_x = 0; min_y = 0; max_x = 65536; max_y = 65536;
      inv_cell = 65536; probe_off = 0; radius_sq = 0; stride = 32;
      foreach (heads[b]) heads[b] = -1;
      count = 0;
      mismatches = 0;
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_index_i, out_status_i, out_last_i};
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result word index=%0d status=%0d last=%0b",
                     $realtime, got.index, got.status, got.last);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t result mismatch: want index=%0d status=%0d last=%0b,",
                        " got index=%0d status=%0d last=%0b"},
                       $realtime, want.index, want.status, want.last,
                       got.index, got.status, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_word(in_op_i, in_x_i, in_y_i);
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
    end
    pending_o <= result_q.size();
    errors_o  <= mismatches;
  end

endmodule

// ----- bench/spatial_hash_close_point_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_hash_close_point_table_tb
// Drives add, add-unique, find-first and find-all words into the point table
// under several grid settings, with random gaps on both channels, and lets
// the checker compare every result word; ends with a single verdict line.
// ----------------------------------------------------------------------------
module spatial_hash_close_point_table_tb;
  import shp_pkg::*;

  localparam int STALL_LIMIT = 200000;  // cycles with no word moving
  localparam int Q_ONE       = 65536;   // 1.0 in Q16.16

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [62:0] cfg_data;
  int          pending;
  int          errors;
  int          quiet_cycles;
  bit          no_gaps;                 // sender runs back to back

  shp_in_if  in_bus ();
  shp_out_if out_bus ();

  spatial_hash_close_point_table u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  shp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_bus.valid),
    .in_ready_i   (in_bus.ready),
    .in_op_i      (in_bus.op),
    .in_x_i       (in_bus.x_coord),
    .in_y_i       (in_bus.y_coord),
    .out_valid_i  (out_bus.valid),
    .out_ready_i  (out_bus.ready),
    .out_index_i  (out_bus.point_index),
    .out_status_i (out_bus.status),
    .out_last_i   (out_bus.last),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .errors_o     (errors)
  );

  // 10 ns clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog: any cycle that moves a word restarts the count
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each word, with runs of no stall
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  // one input word; valid stays high afterwards until the next gap
  task automatic send_word(logic [1:0] op, logic [31:0] x, logic [31:0] y);
    int gap;
    gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.op      = op;
    in_bus.x_coord = x;
    in_bus.y_coord = y;
    in_bus.valid   = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // hold the sender until every result word has come back
  task automatic drain();
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [62:0] d);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic set_grid(int mn_x, int mn_y, int mx_x, int mx_y, logic [31:0] inv,
                          logic [30:0] probe, logic [62:0] rsq, logic [15:0] rstride);
    drain();
    write_reg(REG_BOX_MIN_X,  {31'd0, mn_x[31:0]});
    write_reg(REG_BOX_MIN_Y,  {31'd0, mn_y[31:0]});
    write_reg(REG_BOX_MAX_X,  {31'd0, mx_x[31:0]});
    write_reg(REG_BOX_MAX_Y,  {31'd0, mx_y[31:0]});
    write_reg(REG_INV_CELL,   {31'd0, inv});
    write_reg(REG_PROBE_OFF,  {32'd0, probe});
    write_reg(REG_RADIUS_SQ,  rsq);
    write_reg(REG_ROW_STRIDE, {47'd0, rstride});
  endtask

  // coordinate for the +-100.0 grid: mostly a dense patch, some edges, some noise
  function automatic logic [31:0] main_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom;
    if (pick == 1)
      return ($urandom_range(0, 1) ? 100 * Q_ONE : -100 * Q_ONE) + $urandom_range(0, 15) - 8;
    return -8 * Q_ONE + $urandom_range(0, 16 * Q_ONE);
  endfunction

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_BOX_MIN_X;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.op      = OP_ADD;
    in_bus.x_coord = '0;
    in_bus.y_coord = '0;
    no_gaps        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset grid: unit box, zero radius, so nothing ever matches
    send_word(OP_FIND_FIRST, 32'd0, 32'd0);           // empty table
    send_word(OP_ADD, 32'd0, 32'd0);
    send_word(OP_ADD, 32'hFFFF_FFFF, 32'd0);          // just below the box
    send_word(OP_ADD, 32'd65535, 32'd65535);          // top corner, inside
    send_word(OP_ADD, 32'd65536, 32'd0);              // exclusive upper edge
    send_word(OP_ADD_UNIQUE, 32'd100, 32'd100);
    send_word(OP_ADD_UNIQUE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_FIND_ALL, 32'd0, 32'd0);

    // main grid: box +-100.0, radius 2.0, cell 4.0, probe 1.0, 50 cells a row
    set_grid(-100 * Q_ONE, -100 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE,
             32'd16384, 31'(Q_ONE), 63'd4 << 32, 16'd50);
    send_word(OP_ADD, 32'd0, 32'd0);
    send_word(OP_ADD_UNIQUE, 32'd0, 32'd65536);       // within radius: matched
    send_word(OP_ADD_UNIQUE, 32'd0, 32'd131072);      // exactly on radius: added
    send_word(OP_FIND_FIRST, 32'd0, 32'd32768);
    send_word(OP_FIND_ALL, 32'd0, 32'd65536);
    send_word(OP_FIND_ALL, 32'(50 * Q_ONE), 32'd0);   // no match
    send_word(OP_FIND_ALL, 32'(101 * Q_ONE), 32'd0);  // query and all probes outside
    send_word(OP_ADD, 32'(-100 * Q_ONE), 32'(99 * Q_ONE));
    for (int n = 0; n < 240; n++) begin
      if (n == 120) drain();
      no_gaps = (n % 60) < 15;
      send_word(2'($urandom_range(0, 3)), main_coord(), main_coord());
    end
    no_gaps = 1'b0;

    // extreme grid: full-range box, one cell, widest probe and radius
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'd0, 31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_word(OP_ADD, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_ADD, 32'h7FFF_FFFF, 32'd0);          // upper edge is outside
    send_word(OP_FIND_ALL, 32'h7FFF_FFFE, 32'h7FFF_FFFE);  // squared distance overflows
    for (int n = 0; n < 70; n++)
      send_word(OP_ADD, $urandom_range(0, 255), $urandom_range(0, 255));
    send_word(OP_FIND_ALL, 32'd0, 32'd0);             // capped at the match limit
    for (int n = 0; n < 20; n++)
      send_word(2'($urandom_range(0, 3)), $urandom, $urandom);

    // fine grid: tiny box, widest reciprocal, one cell a row
    set_grid(-4 * Q_ONE, -4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE,
             32'hFFFF_FFFF, 31'd32768, 63'd1 << 32, 16'd1);
    for (int n = 0; n < 40; n++)
      send_word(2'($urandom_range(0, 3)), -5 * Q_ONE + $urandom_range(0, 10 * Q_ONE),
                -5 * Q_ONE + $urandom_range(0, 10 * Q_ONE));

    // back to the main grid, mixed words over the stored points
    set_grid(-100 * Q_ONE, -100 * Q_ONE, 100 * Q_ONE, 100 * Q_ONE,
             32'd16384, 31'(Q_ONE), 63'd4 << 32, 16'd50);
    for (int n = 0; n < 30; n++)
      send_word(2'($urandom_range(0, 3)), main_coord(), main_coord());

    // wait out the last results, then the verdict
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
